// ----- rtl/vps_pkg.sv -----
`timescale 1ns / 1ps

package vps_pkg;

	// Register indexes of the configuration port.
	localparam logic [2:0] REG_WIN_WIDTH  = 3'd0;
	localparam logic [2:0] REG_WIN_HEIGHT = 3'd1;
	localparam logic [2:0] REG_TIME_STEP  = 3'd2;
	localparam logic [2:0] REG_GRAVITY_X  = 3'd3;
	localparam logic [2:0] REG_GRAVITY_Y  = 3'd4;

	// Reset values of the registers.
	localparam logic [15:0] WIN_WIDTH_RST  = 16'd800;
	localparam logic [15:0] WIN_HEIGHT_RST = 16'd600;
	localparam logic [15:0] TIME_STEP_RST  = 16'd1092;

	// Fixed-point layout: Q16.16, so force/mass needs a 48-bit quotient.
	localparam int FRAC_BITS = 16;
	localparam int QUOT_BITS = 48;

	// One axis inside the divider: sign and magnitude of the force,
	// partial remainder and quotient bits developed so far.
	typedef struct packed {
		logic        sgn;
		logic [31:0] mag;
		logic [31:0] rem;
		logic [47:0] quot;
	} dax_t;

	// Everything that travels through the divider stages.
	typedef struct packed {
		logic               locked;
		logic signed [31:0] lock_x;
		logic signed [31:0] lock_y;
		logic signed [31:0] prev_x;
		logic signed [31:0] prev_y;
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic [30:0]        mass;
		dax_t               ax;
		dax_t               ay;
	} dpay_t;

	// Common fields behind the divider.
	typedef struct packed {
		logic               locked;
		logic signed [31:0] lock_x;
		logic signed [31:0] lock_y;
		logic signed [31:0] prev_x;
		logic signed [31:0] prev_y;
		logic signed [31:0] cx;
		logic signed [31:0] cy;
	} side_t;

endpackage

// ----- rtl/vps_if.sv -----
`timescale 1ns / 1ps

// Particle state channel.
interface vps_particle_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] prev_x;
	logic signed [31:0] prev_y;
	logic signed [31:0] force_x;
	logic signed [31:0] force_y;
	logic [30:0]        mass;
	logic [30:0]        radius;
	logic               locked;
	logic signed [31:0] lock_x;
	logic signed [31:0] lock_y;

	modport source (output valid, pos_x, pos_y, prev_x, prev_y, force_x, force_y,
		mass, radius, locked, lock_x, lock_y, input ready);
	modport sink (input valid, pos_x, pos_y, prev_x, prev_y, force_x, force_y,
		mass, radius, locked, lock_x, lock_y, output ready);
endinterface

// Updated position channel.
interface vps_result_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] next_x;
	logic signed [31:0] next_y;
	logic signed [31:0] next_prev_x;
	logic signed [31:0] next_prev_y;

	modport source (output valid, next_x, next_y, next_prev_x, next_prev_y, input ready);
	modport sink (input valid, next_x, next_y, next_prev_x, next_prev_y, output ready);
endinterface

// ----- rtl/vps_div_stage.sv -----
`timescale 1ns / 1ps

// One quotient bit of force*2^16/mass for both axes, with its own
// pipeline register and a ready that lets bubbles collapse.
module vps_div_stage #(
	parameter int BIT = 0
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           valid_i,
	input  vps_pkg::dpay_t data_i,
	output logic           ready_o,
	output logic           valid_o,
	output vps_pkg::dpay_t data_o,
	input  logic           ready_i
);
	import vps_pkg::*;

	logic  valid_s1;
	dpay_t data_s1;
	dpay_t nxt;
	logic  bx;
	logic  by;
	logic [31:0] tx;
	logic [31:0] ty;

	// Dividend bit for this stage; the low fraction bits are zero.
	generate
		if (BIT >= FRAC_BITS) begin : g_hi
			assign bx = data_i.ax.mag[BIT - FRAC_BITS];
			assign by = data_i.ay.mag[BIT - FRAC_BITS];
		end else begin : g_lo
			assign bx = 1'b0;
			assign by = 1'b0;
		end
	endgenerate

	// Restoring step: shift in the bit, subtract the mass when it fits.
	always_comb begin
		nxt = data_i;
		tx  = {data_i.ax.rem[30:0], bx};
		ty  = {data_i.ay.rem[30:0], by};
		if (tx >= {1'b0, data_i.mass}) begin
			nxt.ax.rem       = tx - {1'b0, data_i.mass};
			nxt.ax.quot[BIT] = 1'b1;
		end else begin
			nxt.ax.rem = tx;
		end
		if (ty >= {1'b0, data_i.mass}) begin
			nxt.ay.rem       = ty - {1'b0, data_i.mass};
			nxt.ay.quot[BIT] = 1'b1;
		end else begin
			nxt.ay.rem = ty;
		end
	end

	assign ready_o = !valid_s1 || ready_i;

	// Stage valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_o) begin
			valid_s1 <= valid_i;
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		if (ready_o && valid_i) begin
			data_s1 <= nxt;
		end
	end

	assign valid_o = valid_s1;
	assign data_o  = data_s1;

endmodule

// ----- rtl/verlet_particle_step_top.sv -----
`timescale 1ns / 1ps

// Position Verlet step for one 2D particle in signed Q16.16. The block takes
// one particle on every cycle while the result side keeps up. Each particle
// passes the input stage for the clamp and the force magnitude, the force/mass
// divider, which develops one of its 48 quotient bits per pipeline stage,
// followed by the acceleration, the 32x32 multiply with dt*dt and the final
// sum. A stalled result holds the pipeline back stage by stage, and empty
// stages still take new particles. Configuration must only be written while
// no particle is in flight.
module verlet_particle_step_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_wdata,
	vps_particle_if.sink  particle,
	vps_result_if.source  result
);
	import vps_pkg::*;

	localparam int NDIV = QUOT_BITS;

	// Configuration registers.
	logic [15:0]        win_w_q;
	logic [15:0]        win_h_q;
	logic [15:0]        dt_q;
	logic signed [31:0] grav_x_q;
	logic signed [31:0] grav_y_q;
	logic [31:0]        dt2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_w_q  <= WIN_WIDTH_RST;
			win_h_q  <= WIN_HEIGHT_RST;
			dt_q     <= TIME_STEP_RST;
			grav_x_q <= '0;
			grav_y_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_WIN_WIDTH:  win_w_q  <= cfg_wdata[15:0];
				REG_WIN_HEIGHT: win_h_q  <= cfg_wdata[15:0];
				REG_TIME_STEP:  dt_q     <= cfg_wdata[15:0];
				REG_GRAVITY_X:  grav_x_q <= cfg_wdata;
				REG_GRAVITY_Y:  grav_y_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// dt squared as unsigned Q0.32, registered from dt_q in the cycle after it changes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt2_q <= 32'(TIME_STEP_RST) * 32'(TIME_STEP_RST);
		end else begin
			dt2_q <= 32'(dt_q) * 32'(dt_q);
		end
	end

	// Chain of stage handshakes, index 0 feeds the first divider stage.
	logic  dv [0:NDIV];
	logic  dr [0:NDIV];
	dpay_t dd [0:NDIV];

	// Stage 1: clamp, force magnitude, zero mass guard.
	function automatic logic signed [31:0] clamp_axis(
		input logic signed [31:0] p, input logic [15:0] win, input logic [30:0] rad);
		logic signed [33:0] hi;
		logic signed [33:0] pe;
		logic signed [33:0] re;
		hi = $signed({2'b00, win, 16'h0000}) - $signed({3'b000, rad});
		pe = 34'(p);
		re = $signed({3'b000, rad});
		if (pe > hi) begin
			clamp_axis = hi[31:0];
		end else if (pe < re) begin
			clamp_axis = re[31:0];
		end else begin
			clamp_axis = p;
		end
	endfunction

	logic  v_s1;
	dpay_t d_s1;
	dpay_t s1_nxt;
	logic  rdy_s1;

	always_comb begin
		s1_nxt         = '0;
		s1_nxt.locked  = particle.locked;
		s1_nxt.lock_x  = particle.lock_x;
		s1_nxt.lock_y  = particle.lock_y;
		s1_nxt.prev_x  = particle.prev_x;
		s1_nxt.prev_y  = particle.prev_y;
		s1_nxt.cx      = clamp_axis(particle.pos_x, win_w_q, particle.radius);
		s1_nxt.cy      = clamp_axis(particle.pos_y, win_h_q, particle.radius);
		s1_nxt.mass    = (particle.mass == '0) ? 31'd1 : particle.mass;
		s1_nxt.ax.sgn  = particle.force_x[31];
		s1_nxt.ax.mag  = particle.force_x[31] ? (~particle.force_x + 32'd1)
			: particle.force_x;
		s1_nxt.ay.sgn  = particle.force_y[31];
		s1_nxt.ay.mag  = particle.force_y[31] ? (~particle.force_y + 32'd1)
			: particle.force_y;
	end

	assign rdy_s1         = !v_s1 || dr[0];
	assign particle.ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= particle.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && particle.valid) begin
			d_s1 <= s1_nxt;
		end
	end

	assign dv[0] = v_s1;
	assign dd[0] = d_s1;

	// Divider stages, most significant quotient bit first.
	genvar gi;
	generate
		for (gi = 0; gi < NDIV; gi++) begin : g_div
			vps_div_stage #(.BIT(NDIV - 1 - gi)) u_stage (
				.clk     (clk),
				.arst_n  (arst_n),
				.valid_i (dv[gi]),
				.data_i  (dd[gi]),
				.ready_o (dr[gi]),
				.valid_o (dv[gi + 1]),
				.data_o  (dd[gi + 1]),
				.ready_i (dr[gi + 1])
			);
		end
	endgenerate

	// Acceleration stage: signed quotient plus gravity, saturated.
	function automatic logic signed [31:0] accel(
		input logic signed [31:0] g, input logic sgn, input logic [47:0] q);
		logic signed [48:0] qs;
		logic signed [49:0] s;
		qs = sgn ? -$signed({1'b0, q}) : $signed({1'b0, q});
		s  = 50'(g) + 50'(qs);
		if (s > 50'sd2147483647) begin
			accel = 32'sh7FFFFFFF;
		end else if (s < -50'sd2147483648) begin
			accel = 32'sh80000000;
		end else begin
			accel = s[31:0];
		end
	endfunction

	logic               v_s2;
	side_t              sd_s2;
	logic signed [31:0] acc_x_s2;
	logic signed [31:0] acc_y_s2;
	logic               rdy_s2;
	side_t              sd_in;

	always_comb begin
		sd_in.locked = dd[NDIV].locked;
		sd_in.lock_x = dd[NDIV].lock_x;
		sd_in.lock_y = dd[NDIV].lock_y;
		sd_in.prev_x = dd[NDIV].prev_x;
		sd_in.prev_y = dd[NDIV].prev_y;
		sd_in.cx     = dd[NDIV].cx;
		sd_in.cy     = dd[NDIV].cy;
	end

	assign dr[NDIV] = rdy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= dv[NDIV];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && dv[NDIV]) begin
			sd_s2    <= sd_in;
			acc_x_s2 <= accel(grav_x_q, dd[NDIV].ax.sgn, dd[NDIV].ax.quot);
			acc_y_s2 <= accel(grav_y_q, dd[NDIV].ay.sgn, dd[NDIV].ay.quot);
		end
	end

	// Multiply stage: acc times dt squared, exact Q16.48.
	logic               v_s3;
	side_t              sd_s3;
	logic signed [63:0] prod_x_s3;
	logic signed [63:0] prod_y_s3;
	logic               rdy_s3;
	logic signed [63:0] mul_x;
	logic signed [63:0] mul_y;

	assign mul_x = acc_x_s2 * $signed({1'b0, dt2_q});
	assign mul_y = acc_y_s2 * $signed({1'b0, dt2_q});

	assign rdy_s2 = !v_s2 || rdy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s2) begin
			sd_s3     <= sd_s2;
			prod_x_s3 <= mul_x;
			prod_y_s3 <= mul_y;
		end
	end

	// Final stage: 2*pos - prev + rounded term, saturated; locked: lock position.
	function automatic logic signed [31:0] verlet(
		input logic signed [31:0] c, input logic signed [31:0] p,
		input logic signed [63:0] prod);
		logic signed [34:0] s;
		s = 35'(c) + 35'(c) - 35'(p) + 35'($signed(prod[63:32]))
			+ 35'({34'd0, prod[31]});
		if (s > 35'sd2147483647) begin
			verlet = 32'sh7FFFFFFF;
		end else if (s < -35'sd2147483648) begin
			verlet = 32'sh80000000;
		end else begin
			verlet = s[31:0];
		end
	endfunction

	logic               v_s4;
	logic signed [31:0] nx_s4;
	logic signed [31:0] ny_s4;
	logic signed [31:0] npx_s4;
	logic signed [31:0] npy_s4;

	assign rdy_s3 = !v_s4 || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (rdy_s3) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s3) begin
			if (sd_s3.locked) begin
				nx_s4  <= sd_s3.lock_x;
				ny_s4  <= sd_s3.lock_y;
				npx_s4 <= sd_s3.prev_x;
				npy_s4 <= sd_s3.prev_y;
			end else begin
				nx_s4  <= verlet(sd_s3.cx, sd_s3.prev_x, prod_x_s3);
				ny_s4  <= verlet(sd_s3.cy, sd_s3.prev_y, prod_y_s3);
				npx_s4 <= sd_s3.cx;
				npy_s4 <= sd_s3.cy;
			end
		end
	end

	assign result.valid       = v_s4;
	assign result.next_x      = nx_s4;
	assign result.next_y      = ny_s4;
	assign result.next_prev_x = npx_s4;
	assign result.next_prev_y = npy_s4;

endmodule

// ----- rtl/vps_checker.sv -----
`timescale 1ns / 1ps

// Port-level checks of the particle step block.
module vps_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        p_ready,
	input  logic        r_valid,
	input  logic        r_ready,
	input  logic [127:0] r_data
);

	// A result that is offered stays offered until it is taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && !r_ready |=> r_valid)
		else $error("result valid dropped before transfer");

	// A stalled result keeps its value.
	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && !r_ready |=> $stable(r_data))
		else $error("stalled result changed");

	// With the output free or draining, the pipeline must take a particle.
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		!r_valid || r_ready |-> p_ready)
		else $error("input blocked while output side is free");

	// Nothing comes out in the first cycle after reset.
	a_rst: assert property (@(posedge clk)
		!$past(arst_n) |-> !r_valid)
		else $error("result valid right after reset");

endmodule

bind verlet_particle_step_top vps_checker u_vps_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.p_ready (particle.ready),
	.r_valid (result.valid),
	.r_ready (result.ready),
	.r_data  ({result.next_x, result.next_y, result.next_prev_x, result.next_prev_y})
);
